@@ rtl/core/packed_bcd_binary_converter_macros.svh @@
// Assertion macros for the packed BCD / binary converter.
// Used by the port-level checker; no other dependencies.
`ifndef PACKED_BCD_BINARY_CONVERTER_MACROS_SVH
`define PACKED_BCD_BINARY_CONVERTER_MACROS_SVH

// same-cycle implication
`define PBC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/pbc_pkg.sv @@
// Shared constants, the chain word type and the digit-pair helper.
// No dependencies; used by every module of the converter.
`timescale 1ns / 1ps

package pbc_pkg;

  localparam int MAX_BYTES   = 5;
  localparam int BIN_W       = 32;
  localparam int BCD_W       = 8 * MAX_BYTES;
  localparam int NB_W        = 3;
  localparam int POS_W       = 3;
  localparam int ACC_X_W     = BIN_W + 7;
  localparam int RECIP_SHIFT = 37;

  localparam logic [BIN_W-1:0] RECIP100  = 32'h51EB851F;
  localparam logic [3:0]       DIGIT_MAX = 4'd9;
  localparam logic [NB_W-1:0]  NB_RESET  = 3'd5;

  localparam logic MODE_BIN2BCD = 1'b0;
  localparam logic MODE_BCD2BIN = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [NB_W-1:0]   nb;
    logic [POS_W-1:0]  pos;
    logic [BIN_W-1:0]  v;
    logic [BIN_W-1:0]  acc;
    logic [BCD_W-1:0]  bcd;
    logic              ovf;
    logic              bad;
  } pbc_word_t;

  // value 0..99 to one packed BCD byte
  function automatic logic [7:0] pbc_pair_byte(input logic [6:0] pair);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  tens10;
    logic [6:0]  ones;
    prod   = 15'(pair) * 15'd205;
    tens   = prod[14:11];
    tens10 = (7'(tens) << 3) + (7'(tens) << 1);
    ones   = pair - tens10;
    return {tens, ones[3:0]};
  endfunction

endpackage

@@ rtl/core/pbc_cell.sv @@
// One cell of the conversion chain: handles one digit pair in two register stages.
// Depends on pbc_pkg.
`timescale 1ns / 1ps

module pbc_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  output logic              up_ready,
  input  pbc_pkg::pbc_word_t up_word,
  output logic              dn_valid,
  input  logic              dn_ready,
  output pbc_pkg::pbc_word_t dn_word
);
  import pbc_pkg::*;

  logic               va;
  pbc_word_t          wa;
  logic [2*BIN_W-1:0] prod;
  logic [ACC_X_W-1:0] mul100;
  logic [7:0]         digit;
  logic               ready_a;

  logic               vb;
  pbc_word_t          wb;
  logic               ready_b;

  logic               used_in;
  logic [3:0]         hi;
  logic [3:0]         lo;
  logic [ACC_X_W-1:0] acc_x;
  pbc_word_t          wa_next;

  logic               used_a;
  logic [BIN_W-1:0]   q;
  logic [BIN_W-1:0]   q100;
  logic [BIN_W-1:0]   rem;
  logic [ACC_X_W-1:0] sum;
  pbc_word_t          wb_next;

  assign ready_b  = !vb || dn_ready;
  assign ready_a  = !va || ready_b;
  assign up_ready = ready_a;
  assign dn_valid = vb;
  assign dn_word  = wb;

  // stage A: reciprocal product, or scaled accumulator and checked digit pair value
  always_comb begin
    used_in = up_word.pos < up_word.nb;
    hi      = up_word.bcd[BCD_W-1 -: 4];
    lo      = up_word.bcd[BCD_W-5 -: 4];
    acc_x   = ACC_X_W'(up_word.acc);
    wa_next = up_word;
    if (up_word.mode == MODE_BCD2BIN) begin
      wa_next.bcd = up_word.bcd << 8;
      if (used_in && (hi > DIGIT_MAX || lo > DIGIT_MAX)) begin
        wa_next.bad = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (ready_a) begin
      va <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && up_valid) begin
      wa     <= wa_next;
      prod   <= (2*BIN_W)'(up_word.v) * (2*BIN_W)'(RECIP100);
      mul100 <= (acc_x << 6) + (acc_x << 5) + (acc_x << 2);
      digit  <= (8'(hi) << 3) + (8'(hi) << 1) + 8'(lo);
    end
  end

  // stage B: emit the digit pair or fold in the byte value
  always_comb begin
    used_a  = wa.pos < wa.nb;
    q       = BIN_W'(prod >> RECIP_SHIFT);
    q100    = (q << 6) + (q << 5) + (q << 2);
    rem     = wa.v - q100;
    sum     = mul100 + ACC_X_W'(digit);
    wb_next = wa;
    if (wa.mode == MODE_BIN2BCD) begin
      wb_next.pos = wa.pos + 1'b1;
      if (used_a) begin
        wb_next.v   = q;
        wb_next.bcd = {pbc_pair_byte(rem[6:0]), wa.bcd[BCD_W-1:8]};
      end else begin
        wb_next.bcd = {8'h00, wa.bcd[BCD_W-1:8]};
      end
    end else begin
      wb_next.pos = wa.pos - 1'b1;
      if (used_a) begin
        wb_next.acc = sum[BIN_W-1:0];
        wb_next.ovf = wa.ovf || (sum[ACC_X_W-1:BIN_W] != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (ready_b) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_b && va) begin
      wb <= wb_next;
    end
  end

endmodule

@@ rtl/core/packed_bcd_binary_converter.sv @@
// Packed BCD / binary converter top level: config register, chain of cells, output register.
// Depends on pbc_pkg and pbc_cell.
//
// Usage:
//   Source channel (src_valid / src_stall) carries func, bin_value and bcd_value.
//   func 0 converts bin_value to num_bytes packed BCD bytes; overflow marks dropped
//   digits. func 1 converts the low num_bytes bytes of bcd_value to binary modulo
//   2^32; overflow marks a value past 32 bits, bad_digit a nibble above 9.
//   Sink channel (dst_valid / dst_stall) returns one result per transfer.
//   Config channel (cfg_valid / cfg_ready / cfg_data) writes num_bytes; cfg_ready
//   is always high. Write it only while no conversion is in flight.
// Timing:
//   Five cells of two register stages each plus the output register. One transfer
//   per cycle is sustained while the sink does not stall.
// Reset: empties the chain and the output register, num_bytes returns to 5.
// Stall: a stalled result holds; bubbles in the chain still close up, so new
//   transfers are taken until the chain is full, then src_stall rises.
`timescale 1ns / 1ps

module packed_bcd_binary_converter (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [pbc_pkg::NB_W-1:0]  cfg_data,
  input  logic                      src_valid,
  output logic                      src_stall,
  input  logic                      func,
  input  logic [pbc_pkg::BIN_W-1:0] bin_value,
  input  logic [pbc_pkg::BCD_W-1:0] bcd_value,
  output logic                      dst_valid,
  input  logic                      dst_stall,
  output logic [pbc_pkg::BIN_W-1:0] bin_result,
  output logic [pbc_pkg::BCD_W-1:0] bcd_result,
  output logic                      overflow,
  output logic                      bad_digit
);
  import pbc_pkg::*;

  logic [NB_W-1:0] num_bytes;
  logic [NB_W-1:0] nb_used;
  pbc_word_t       src_word;

  logic            chain_valid [MAX_BYTES+1];
  logic            chain_ready [MAX_BYTES+1];
  pbc_word_t       chain_word  [MAX_BYTES+1];

  pbc_word_t       last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_bytes <= NB_RESET;
    end else if (cfg_valid && cfg_ready) begin
      num_bytes <= cfg_data;
    end
  end

  always_comb begin
    if (num_bytes == '0) begin
      nb_used = NB_W'(1);
    end else if (32'(num_bytes) > MAX_BYTES) begin
      nb_used = NB_W'(MAX_BYTES);
    end else begin
      nb_used = num_bytes;
    end
  end

  always_comb begin
    src_word      = '0;
    src_word.mode = func;
    src_word.nb   = nb_used;
    src_word.v    = bin_value;
    if (func == MODE_BCD2BIN) begin
      src_word.pos = POS_W'(MAX_BYTES - 1);
      src_word.bcd = bcd_value;
    end
  end

  assign chain_valid[0] = src_valid;
  assign chain_word[0]  = src_word;
  assign src_stall      = !chain_ready[0];

  for (genvar k = 0; k < MAX_BYTES; k++) begin : g_cell
    pbc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (chain_valid[k]),
      .up_ready (chain_ready[k]),
      .up_word  (chain_word[k]),
      .dn_valid (chain_valid[k+1]),
      .dn_ready (chain_ready[k+1]),
      .dn_word  (chain_word[k+1])
    );
  end

  assign chain_ready[MAX_BYTES] = !dst_valid || !dst_stall;
  assign last                   = chain_word[MAX_BYTES];

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (chain_ready[MAX_BYTES]) begin
      dst_valid <= chain_valid[MAX_BYTES];
    end
  end

  always_ff @(posedge clk) begin
    if (chain_ready[MAX_BYTES] && chain_valid[MAX_BYTES]) begin
      if (last.mode == MODE_BCD2BIN) begin
        bin_result <= last.acc;
        bcd_result <= '0;
        overflow   <= last.ovf;
        bad_digit  <= last.bad;
      end else begin
        bin_result <= '0;
        bcd_result <= last.bcd;
        overflow   <= last.v != '0;
        bad_digit  <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/pbc_checker.sv @@
// Port-level checker for the packed BCD / binary converter, bound to the top level.
// Depends on pbc_pkg and packed_bcd_binary_converter_macros.svh.
`timescale 1ns / 1ps
`include "packed_bcd_binary_converter_macros.svh"

module pbc_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      dst_valid,
  input logic                      dst_stall,
  input logic [pbc_pkg::BIN_W-1:0] bin_result,
  input logic [pbc_pkg::BCD_W-1:0] bcd_result,
  input logic                      bad_digit
);
  import pbc_pkg::*;

  `PBC_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !dst_valid, "result valid right after reset")
  `PBC_ASSERT_NEXT(a_hold_valid, clk, rst, dst_valid && dst_stall, dst_valid, "stalled result dropped")
  `PBC_ASSERT_NOW(a_bad_mode, clk, rst, dst_valid && bad_digit, bcd_result == '0, "bad digit with BCD result")
  `PBC_ASSERT_NOW(a_one_mode, clk, rst, dst_valid && bin_result != '0, bcd_result == '0, "both results nonzero")

endmodule

bind packed_bcd_binary_converter pbc_checker u_pbc_checker (
  .clk        (clk),
  .rst        (rst),
  .dst_valid  (dst_valid),
  .dst_stall  (dst_stall),
  .bin_result (bin_result),
  .bcd_result (bcd_result),
  .bad_digit  (bad_digit)
);
